// ----- rtl/core/tsvu_pkg.sv -----
// Shared types and character constants for the TSV field unescaper.
package tsvu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_ERR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        line_end;
    logic        last;
  } result_t;

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NL  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_BSL = 8'd92;
  localparam logic [7:0] CH_LC_N = 8'h6e;
  localparam logic [7:0] CH_LC_R = 8'h72;
  localparam logic [7:0] CH_LC_T = 8'h74;

  localparam logic [7:0] DELIM_RESET = CH_TAB;

endpackage

// ----- rtl/core/tsvu_decode.sv -----
// Per-byte decode: escape and line state in, up to two results and next state out.
module tsvu_decode
  import tsvu_pkg::*;
(
  input  logic [7:0] byte_i,
  input  logic       line_start_i,
  input  logic [7:0] delim_i,
  input  logic       esc_i,
  input  logic       ended_i,
  output logic [1:0] n_res_o,
  output result_t    res0_o,
  output result_t    res1_o,
  output logic       esc_o,
  output logic       ended_o
);

  logic esc_eff, ended_eff, is_delim, is_eol;

  assign esc_eff   = esc_i & ~line_start_i;
  assign ended_eff = ended_i & ~line_start_i;
  assign is_delim  = (byte_i == delim_i);
  assign is_eol    = (byte_i == CH_NL) || (byte_i == CH_CR) || (byte_i == CH_NUL);

  always_comb begin
    n_res_o = 2'd0;
    res0_o  = '{kind: KIND_DATA, data: 8'd0, line_end: 1'b0, last: 1'b0};
    res1_o  = '{kind: KIND_DATA, data: 8'd0, line_end: 1'b0, last: 1'b1};
    esc_o   = esc_eff;
    ended_o = ended_eff;
    if (!ended_eff) begin
      if (esc_eff) begin
        esc_o = 1'b0;
        if (is_delim || is_eol) begin
          n_res_o          = 2'd2;
          res0_o.data      = CH_BSL;
          res1_o.kind      = KIND_END_ERR;
          res1_o.line_end  = ~is_delim;
          ended_o          = ~is_delim;
        end else if (byte_i == CH_LC_N) begin
          n_res_o     = 2'd1;
          res0_o.data = CH_NL;
        end else if (byte_i == CH_LC_R) begin
          n_res_o     = 2'd1;
          res0_o.data = CH_CR;
        end else if (byte_i == CH_LC_T) begin
          n_res_o     = 2'd1;
          res0_o.data = CH_TAB;
        end else if (byte_i == CH_BSL) begin
          n_res_o     = 2'd1;
          res0_o.data = CH_BSL;
        end else begin
          // unknown escape: keep the backslash and the byte
          n_res_o     = 2'd2;
          res0_o.data = CH_BSL;
          res1_o.data = byte_i;
        end
      end else if (is_delim) begin
        n_res_o     = 2'd1;
        res0_o.kind = KIND_END_OK;
      end else if (is_eol) begin
        n_res_o         = 2'd1;
        res0_o.kind     = KIND_END_OK;
        res0_o.line_end = 1'b1;
        ended_o         = 1'b1;
      end else if (byte_i == CH_BSL) begin
        esc_o = 1'b1;
      end else begin
        n_res_o     = 2'd1;
        res0_o.data = byte_i;
      end
    end
    res0_o.last = (n_res_o == 2'd1);
  end

endmodule

// ----- rtl/core/tsvu_result_queue.sv -----
// Three-entry result queue; takes up to two results per transfer, sends one per cycle while ready_i is high.
module tsvu_result_queue
  import tsvu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] n_res_i,
  input  result_t    res0_i,
  input  result_t    res1_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output result_t    head_o
);

  localparam int QDepth = 3;

  result_t    ent_q [QDepth];
  result_t    ent_d [QDepth];
  logic [1:0] count_q, count_d, cap;
  logic       pop;
  logic [1:0] n_push;

  // room for a two-result transfer regardless of the output side
  assign room_o  = (count_q <= 2'd1);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = ent_q[0];
  assign pop     = valid_o & ready_i;
  assign n_push  = push_i ? n_res_i : 2'd0;
  assign cap     = count_q - {1'b0, pop};
  assign count_d = cap + n_push;

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i < QDepth - 1)) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if ((n_push != 2'd0) && (cap == 2'(i))) begin
        ent_d[i] = res0_i;
      end
      if ((n_push == 2'd2) && ((cap + 2'd1) == 2'(i))) begin
        ent_d[i] = res1_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && (n_res_i != 2'd0)) |-> (count_q <= 2'd1))
    else $error("result queue overflow");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (n_push == 2'd0)) |=> (count_q == $past(count_q) - 2'd1))
    else $error("pop without push did not drop count");

  a_push_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pop && (n_push == 2'd2)) |=> (count_q == $past(count_q) + 2'd2))
    else $error("two-result transfer not stored");

endmodule

// ----- rtl/core/tsv_field_unescaper_top.sv -----
// Top level of the TSV field splitter and unescaper.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid_i/tready_o      tdata: byte_in; tuser: line_start
//  m_axis    out  m_axis_tvalid_o/tready_i      tdata: data_byte; tuser: kind, line_end;
//                                               tlast: last
//  cfg       in   cfg_we_i                      cfg_wdata_i: delimiter
//
// One byte per cycle while the queue has room: the decode sits between the input
// port and a three-entry result queue. A byte that yields two results holds
// tready low while the queue drains. tready depends only on the queue fill,
// not on m_axis_tready_i. Reset clears the escape and line flags, empties the
// queue and sets the delimiter to tab.
module tsv_field_unescaper_top
  import tsvu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] byte_in
  input  logic       s_axis_tuser_i,   // [0] line_start
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic [2:0] m_axis_tuser_o,   // [1:0] kind, [2] line_end
  output logic       m_axis_tlast_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic [7:0] delim_q;
  logic       esc_q, esc_d, ended_q, ended_d;
  logic       in_xfer, room;
  logic [1:0] n_res;
  result_t    res0, res1, head;

  assign s_axis_tready_o = room;
  assign in_xfer = s_axis_tvalid_i & room;

  tsvu_decode u_decode (
    .byte_i       (s_axis_tdata_i),
    .line_start_i (s_axis_tuser_i),
    .delim_i      (delim_q),
    .esc_i        (esc_q),
    .ended_i      (ended_q),
    .n_res_o      (n_res),
    .res0_o       (res0),
    .res1_o       (res1),
    .esc_o        (esc_d),
    .ended_o      (ended_d)
  );

  tsvu_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .n_res_i (n_res),
    .res0_i  (res0),
    .res1_i  (res1),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .head_o  (head)
  );

  assign m_axis_tdata_o = head.data;
  assign m_axis_tuser_o = {head.line_end, head.kind};
  assign m_axis_tlast_o = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
      esc_q   <= 1'b0;
      ended_q <= 1'b0;
    end else begin
      // line-ending bytes and backslash cannot serve as delimiter
      if (cfg_we_i && (cfg_wdata_i != CH_NL) && (cfg_wdata_i != CH_CR) &&
          (cfg_wdata_i != CH_BSL) && (cfg_wdata_i != CH_NUL)) begin
        delim_q <= cfg_wdata_i;
      end
      if (in_xfer) begin
        esc_q   <= esc_d;
        ended_q <= ended_d;
      end
    end
  end

  a_ended_no_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> !esc_q)
    else $error("escape pending after line end");

  a_ended_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && ended_q && !s_axis_tuser_i) |-> (n_res == 2'd0))
    else $error("result produced after line end");

  a_delim_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (delim_q != CH_NL) && (delim_q != CH_CR) && (delim_q != CH_BSL) && (delim_q != CH_NUL))
    else $error("forbidden delimiter stored");

endmodule
